// ===== rtl/lswd_pkg.sv =====
// Shared constants and handshake structs for the lidar scan wall detector.
package lswd_pkg;

  localparam int unsigned MaxScanSamples = 1024;
  localparam int unsigned MaxHalfWindow  = 32;

  localparam int unsigned RangeW = 16;
  localparam int unsigned IndexW = $clog2(MaxScanSamples);
  localparam int unsigned HalfW  = 6;
  localparam int unsigned CountW = $clog2(2 * MaxHalfWindow + 2);
  localparam int unsigned TotalW = RangeW + 4;
  localparam int unsigned RemW   = CountW;
  localparam int unsigned StepW  = $clog2(TotalW);

  localparam logic [RangeW-1:0] RangeLowMm  = RangeW'(100);
  localparam logic [RangeW-1:0] RangeHighMm = RangeW'(15000);
  localparam logic [RangeW-1:0] EmptyAvgMm  = RangeW'(120);

  // Configuration register indexes.
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] RegLeftCenter  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegRightCenter = 3'd1;
  localparam logic [CfgAddrW-1:0] RegFrontCenter = 3'd2;
  localparam logic [CfgAddrW-1:0] RegSideHalf    = 3'd3;
  localparam logic [CfgAddrW-1:0] RegFrontHalf   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegSideWall    = 3'd5;
  localparam logic [CfgAddrW-1:0] RegFrontWall   = 3'd6;

  // Steering codes.
  localparam logic [1:0] SteerForward = 2'd0;
  localparam logic [1:0] SteerLeft    = 2'd1;
  localparam logic [1:0] SteerRight   = 2'd2;

  typedef struct packed {
    logic              start;
    logic [TotalW-1:0] dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TotalW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/lswd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module lswd_div (
  input  logic               clk,
  input  logic               rst,
  input  lswd_pkg::div_req_t req,
  output lswd_pkg::div_rsp_t rsp
);

  logic                        busy;
  logic                        done;
  logic [lswd_pkg::StepW-1:0]  step;
  logic [lswd_pkg::TotalW-1:0] quo;
  logic [lswd_pkg::RemW-1:0]   rem;
  logic [lswd_pkg::CountW-1:0] divisor;

  logic [lswd_pkg::RemW:0]     trial;
  logic                        fits;

  assign trial = {rem, quo[lswd_pkg::TotalW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy    <= 1'b1;
        step    <= '0;
        quo     <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= lswd_pkg::RemW'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[lswd_pkg::RemW-1:0];
        end
        quo <= {quo[lswd_pkg::TotalW-2:0], fits};
        if (step == lswd_pkg::StepW'(lswd_pkg::TotalW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/lidar_scan_wall_detector.sv =====
// Top level of the lidar scan wall detector: scan tracking, end-of-scan sequencer, output.
//
// The block takes one range sample per beat on the slave stream, with tlast marking the
// final sample of a scan. Each sample that is not the last is absorbed as it is accepted:
// the running minimum and its index are updated, and the sample is added to the left and
// right window sums when it is valid (above 100 mm and below 15000 mm) and lies in that
// window. Only the first 1024 samples of a scan count; later ones are ignored until tlast.
// On the last sample the block drops tready and runs the two window averages one after
// the other through a shared bit-serial divider that produces one quotient bit per cycle;
// tready stays low through the left and right start and wait states and the emit state
// that loads the result, plus any time spent waiting for the previous result to leave.
// A window with no valid sample reports 120 mm. The result beat then sits in an output
// register until the master side takes it; the block accepts samples of the next scan
// meanwhile, and only holds off a second end of scan until the first result is gone.
// Configuration is written through the plain write port; the user must do so only while
// the block is idle (not enforced by the block). Half widths above 32 are treated as 32.
module lidar_scan_wall_detector (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Sample stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] range_mm
  input  logic        s_tlast,  // last_sample
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // [1:0] steer_command, [17:2] min_range,
                                // [27:18] min_position, [43:28] left_average,
                                // [59:44] right_average, [60] wall_left,
                                // [61] wall_right, [62] wall_front, [63] zero
);

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StLStart = 3'd1;
  localparam logic [2:0] StLWait  = 3'd2;
  localparam logic [2:0] StRStart = 3'd3;
  localparam logic [2:0] StRWait  = 3'd4;
  localparam logic [2:0] StEmit   = 3'd5;

  localparam int unsigned IdxW = lswd_pkg::IndexW;
  localparam int unsigned RW   = lswd_pkg::RangeW;
  localparam int unsigned HW   = lswd_pkg::HalfW;

  // True when idx lies within centre +/- half, computed without wrap.
  function automatic logic in_window(input logic [IdxW-1:0] idx,
                                     input logic [IdxW-1:0] centre,
                                     input logic [HW-1:0] half);
    logic [IdxW:0] lo_sum;
    logic [IdxW:0] hi_sum;
    lo_sum = {1'b0, idx} + (IdxW + 1)'(half);
    hi_sum = {1'b0, centre} + (IdxW + 1)'(half);
    return (lo_sum >= {1'b0, centre}) && ({1'b0, idx} <= hi_sum);
  endfunction

  function automatic logic [HW-1:0] clamp_half(input logic [HW-1:0] h);
    return (h > HW'(lswd_pkg::MaxHalfWindow)) ? HW'(lswd_pkg::MaxHalfWindow) : h;
  endfunction

  // Configuration registers.
  logic [IdxW-1:0] left_center;
  logic [IdxW-1:0] right_center;
  logic [IdxW-1:0] front_center;
  logic [HW-1:0]   side_half;
  logic [HW-1:0]   front_half;
  logic [RW-1:0]   side_wall_mm;
  logic [RW-1:0]   front_wall_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_center   <= '0;
      right_center  <= '0;
      front_center  <= '0;
      side_half     <= '0;
      front_half    <= '0;
      side_wall_mm  <= '0;
      front_wall_mm <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        lswd_pkg::RegLeftCenter:  left_center   <= cfg_wdata[IdxW-1:0];
        lswd_pkg::RegRightCenter: right_center  <= cfg_wdata[IdxW-1:0];
        lswd_pkg::RegFrontCenter: front_center  <= cfg_wdata[IdxW-1:0];
        lswd_pkg::RegSideHalf:    side_half     <= cfg_wdata[HW-1:0];
        lswd_pkg::RegFrontHalf:   front_half    <= cfg_wdata[HW-1:0];
        lswd_pkg::RegSideWall:    side_wall_mm  <= cfg_wdata[RW-1:0];
        lswd_pkg::RegFrontWall:   front_wall_mm <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // Scan state.
  logic [2:0]                  state;
  logic [IdxW-1:0]             sample_count;
  logic                        scan_full;
  logic [RW-1:0]               best_range;
  logic [IdxW-1:0]             best_position;
  logic [lswd_pkg::TotalW-1:0] left_total;
  logic [lswd_pkg::TotalW-1:0] right_total;
  logic [lswd_pkg::CountW-1:0] left_valid;
  logic [lswd_pkg::CountW-1:0] right_valid;
  logic [RW-1:0]               left_avg;
  logic [RW-1:0]               right_avg;

  logic [RW-1:0] range_mm;
  logic          accept;
  logic          sample_ok;
  logic [HW-1:0] side_half_eff;
  logic          hit_left;
  logic          hit_right;

  assign range_mm      = s_tdata[RW-1:0];
  assign s_tready      = (state == StIdle);
  assign accept        = s_tvalid && s_tready;
  assign sample_ok     = (range_mm > lswd_pkg::RangeLowMm) && (range_mm < lswd_pkg::RangeHighMm);
  assign side_half_eff = clamp_half(side_half);
  assign hit_left      = sample_ok && in_window(sample_count, left_center, side_half_eff);
  assign hit_right     = sample_ok && in_window(sample_count, right_center, side_half_eff);

  // Shared divider.
  lswd_pkg::div_req_t div_req;
  lswd_pkg::div_rsp_t div_rsp;

  always_comb begin
    div_req.start    = (state == StLStart) || (state == StRStart);
    div_req.dividend = (state == StRStart) ? right_total : left_total;
    div_req.divisor  = (state == StRStart) ? right_valid : left_valid;
  end

  lswd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // End-of-scan decisions, evaluated while the result is loaded.
  logic          wall_left;
  logic          wall_right;
  logic          wall_front;
  logic [1:0]    steer;
  logic          emit_go;

  assign wall_left  = left_avg <= side_wall_mm;
  assign wall_right = right_avg <= side_wall_mm;
  assign wall_front = in_window(best_position, front_center, clamp_half(front_half)) &&
                      (best_range <= front_wall_mm);

  always_comb begin
    if (!wall_right) begin
      steer = lswd_pkg::SteerRight;
    end else if (wall_front) begin
      steer = lswd_pkg::SteerLeft;
    end else begin
      steer = lswd_pkg::SteerForward;
    end
  end

  assign emit_go = (state == StEmit) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StIdle;
      sample_count  <= '0;
      scan_full     <= 1'b0;
      best_range    <= '1;
      best_position <= '0;
      left_total    <= '0;
      right_total   <= '0;
      left_valid    <= '0;
      right_valid   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // A new result may replace the one leaving in the same cycle.
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (accept) begin
            if (!scan_full) begin
              if (range_mm < best_range) begin
                best_range    <= range_mm;
                best_position <= sample_count;
              end
              if (hit_left) begin
                left_total <= left_total + lswd_pkg::TotalW'(range_mm);
                left_valid <= left_valid + 1'b1;
              end
              if (hit_right) begin
                right_total <= right_total + lswd_pkg::TotalW'(range_mm);
                right_valid <= right_valid + 1'b1;
              end
              if (sample_count == IdxW'(lswd_pkg::MaxScanSamples - 1)) begin
                scan_full <= 1'b1;
              end else begin
                sample_count <= sample_count + 1'b1;
              end
            end
            if (s_tlast) begin
              state <= StLStart;
            end
          end
        end
        StLStart: state <= StLWait;
        StLWait: begin
          if (div_rsp.done) begin
            left_avg <= (left_valid == '0) ? lswd_pkg::EmptyAvgMm
                                           : div_rsp.quotient[RW-1:0];
            state    <= StRStart;
          end
        end
        StRStart: state <= StRWait;
        StRWait: begin
          if (div_rsp.done) begin
            right_avg <= (right_valid == '0) ? lswd_pkg::EmptyAvgMm
                                             : div_rsp.quotient[RW-1:0];
            state     <= StEmit;
          end
        end
        StEmit: begin
          if (emit_go) begin
            m_tdata       <= {1'b0, wall_front, wall_right, wall_left, right_avg, left_avg,
                              best_position, best_range, steer};
            sample_count  <= '0;
            scan_full     <= 1'b0;
            best_range    <= '1;
            best_position <= '0;
            left_total    <= '0;
            right_total   <= '0;
            left_valid    <= '0;
            right_valid   <= '0;
            state         <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule
